@@ hw/rtl/hvd_pkg.sv @@
// Shared types, stage numbering and Q31 helper functions for the haversine distance pipeline.
// Depends on nothing; used by hvd_lookup, hvd_sqrt and haversine_distance_q31.
package hvd_pkg;

  localparam int STAGE_LOOKUP = 1;
  localparam int LOOKUP_DEPTH = 4;
  localparam int SQRT_STEPS   = 31;
  localparam int STAGE_SQRT   = 9;
  localparam int STAGE_SCALE  = STAGE_SQRT + SQRT_STEPS;
  localparam int NUM_STAGES   = STAGE_SCALE + 2;

  localparam logic [23:0] TWO_RADIUS_M = 24'd12745590;
  localparam logic signed [31:0] HALF_DIFF_SCALE = 32'sd298;
  localparam logic signed [31:0] LAT_SCALE = 32'sd596;
  localparam logic [30:0] QUARTER_TURN = 31'h2000_0000;

  typedef logic signed [31:0] q31_t;

  function automatic q31_t sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic q31_t q31_norm(input logic signed [63:0] p);
    logic signed [31:0] t;
    t = p[63:32];
    if (t > 32'sh3FFF_FFFF) begin
      t = 32'sh3FFF_FFFF;
    end else if (t < -32'sh4000_0000) begin
      t = -32'sh4000_0000;
    end
    return {t[30:0], 1'b0};
  endfunction

endpackage

@@ hw/rtl/hvd_lookup.sv @@
// Four-stage table sine unit: index split, table read, interpolation products, sum.
// Depends on hvd_pkg; the sine table is built at elaboration from SINE_TABLE_SIZE.
module hvd_lookup import hvd_pkg::*; #(
  parameter int SINE_TABLE_SIZE = 512
) (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [30:0] u_i,
  output q31_t        val_o
);

  localparam int IW = $clog2(SINE_TABLE_SIZE);
  localparam int AW = $clog2(SINE_TABLE_SIZE + 1);
  localparam int WW = 31 + AW;
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  typedef logic signed [31:0] tab_t [0:SINE_TABLE_SIZE];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] sin_q60(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x2 = mul_q60(x, x);
    term = x;
    acc = x;
    for (int k = 1; k <= 15; k++) begin
      term = mul_q60(term, x2) / 64'(2 * k * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] q;
    logic neg;
    for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
      m = 64'(2 * i);
      neg = 1'b0;
      if (m > 64'(SINE_TABLE_SIZE)) begin
        neg = 1'b1;
        m = m - 64'(SINE_TABLE_SIZE);
      end
      if (2 * m > 64'(SINE_TABLE_SIZE)) begin
        m = 64'(SINE_TABLE_SIZE) - m;
      end
      x = (PI_Q60 / SINE_TABLE_SIZE) * m + ((PI_Q60 % SINE_TABLE_SIZE) * m) / SINE_TABLE_SIZE;
      q = (sin_q60(x) + 64'h1000_0000) >> 29;
      if (neg) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
        end
        t[i] = ~q[31:0] + 32'd1;
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
        end
        t[i] = q[31:0];
      end
    end
    return t;
  endfunction

  localparam tab_t SineTab = build_tab();

  logic [WW-1:0]           w;
  logic [IW-1:0]           idx_q;
  logic [30:0]             f1_q, f2_q;
  q31_t                    ta_q, tb_q;
  logic [31:0]             omf;
  logic signed [64:0]      pa_d, pa_q;
  logic signed [63:0]      pb_d, pb_q;
  logic signed [34:0]      s;
  q31_t                    val_q;

  assign w    = {{AW{1'b0}}, u_i} * WW'(SINE_TABLE_SIZE);
  assign omf  = 32'h8000_0000 - {1'b0, f2_q};
  assign pa_d = $signed({1'b0, omf}) * ta_q;
  assign pb_d = $signed({1'b0, f2_q}) * tb_q;
  assign s    = 35'(pa_q >>> 32) + 35'(pb_q >>> 32);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      idx_q <= w[31 +: IW];
      f1_q  <= w[30:0];
    end
    if (en_i[1]) begin
      ta_q <= SineTab[AW'(idx_q)];
      tb_q <= SineTab[AW'(idx_q) + AW'(1)];
      f2_q <= f1_q;
    end
    if (en_i[2]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (en_i[3]) begin
      val_q <= sat32({s, 1'b0});
    end
  end

  assign val_o = val_q;

endmodule

@@ hw/rtl/hvd_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage, of a 62-bit radicand.
// Depends on hvd_pkg for the step count.
module hvd_sqrt import hvd_pkg::*; (
  input  logic                  clk_i,
  input  logic [SQRT_STEPS-1:0] en_i,
  input  logic [61:0]           rad_i,
  output logic [30:0]           root_o
);

  logic [61:0] v_q   [0:SQRT_STEPS-2];
  logic [32:0] rem_q [0:SQRT_STEPS-2];
  logic [30:0] r_q   [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [61:0] v_in;
    logic [32:0] rem_in;
    logic [30:0] r_in;
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        take;
    logic [34:0] diff;

    if (k == 0) begin : g_first
      assign v_in   = rad_i;
      assign rem_in = '0;
      assign r_in   = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign r_in   = r_q[k-1];
    end

    assign rem2  = {rem_in, v_in[61:60]};
    assign trial = {2'b00, r_in, 2'b01};
    assign take  = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k] <= {r_in[29:0], take};
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          v_q[k]   <= {v_in[59:0], 2'b00};
          rem_q[k] <= take ? diff[32:0] : rem2[32:0];
        end
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS-1];

endmodule

@@ hw/rtl/haversine_distance_q31.sv @@
// Top level of the haversine distance pipeline: angle scaling, four sine units,
// Q31 products, square root and metre scaling. Depends on hvd_pkg, hvd_lookup, hvd_sqrt.
//
//  channel | signals                                  | direction
//  input   | in_valid_i, in_ready_o, lat/lon a and b  | in
//  output  | out_valid_o, out_ready_i, distance_m_o   | out
//
// A result transfers out when out_valid_o and out_ready_i are both high; one item may enter
// every cycle unless the pipeline is full and the output is stalled.
// The pipeline has 42 register stages, 31 of them in the bit-per-stage square root.
// Reset clears the stage valid bits only.
// Each stage holds while the next is full and stalled, so bubbles close up under a stall.
module haversine_distance_q31 import hvd_pkg::*; #(
  parameter int SINE_TABLE_SIZE = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [20:0] lat_a_i,
  input  logic signed [21:0] lon_a_i,
  input  logic signed [20:0] lat_b_i,
  input  logic signed [21:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        distance_m_o
);

  logic [NUM_STAGES-1:0] v_q, v_d;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  logic signed [31:0] dlat, dlon, plat, plon, sa, sb;
  logic [30:0] u_q [0:3];
  q31_t        lk  [0:3];

  assign dlat = 32'(lat_b_i) - 32'(lat_a_i);
  assign dlon = 32'(lon_a_i) - 32'(lon_b_i);
  assign plat = dlat * HALF_DIFF_SCALE;
  assign plon = dlon * HALF_DIFF_SCALE;
  assign sa   = 32'(lat_a_i) * LAT_SCALE;
  assign sb   = 32'(lat_b_i) * LAT_SCALE;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q[0] <= plat[31] ? 31'(-plat) : plat[30:0];
      u_q[1] <= plon[31] ? 31'(-plon) : plon[30:0];
      u_q[2] <= sa[30:0] + QUARTER_TURN;
      u_q[3] <= sb[30:0] + QUARTER_TURN;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lookup
    hvd_lookup #(
      .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
    ) u_lookup (
      .clk_i (clk_i),
      .en_i  (en[STAGE_LOOKUP +: LOOKUP_DEPTH]),
      .u_i   (u_q[g]),
      .val_o (lk[g])
    );
  end

  localparam int S5 = STAGE_LOOKUP + LOOKUP_DEPTH;

  logic signed [63:0] p_cc_q, p_lon_q, p_lat_q, p4_q;
  q31_t               m_cc_q, m_lon_q, m_lat_q, m_lat2_q;
  logic signed [63:0] p4_d;
  q31_t               sum;
  logic [61:0]        rad_q;
  logic [30:0]        root;
  logic [54:0]        prod_q;
  logic [23:0]        dist_q;

  assign p4_d = m_cc_q * m_lon_q;
  assign sum  = sat32(36'(q31_norm(p4_q)) + 36'(m_lat2_q));

  always_ff @(posedge clk_i) begin
    if (en[S5]) begin
      p_cc_q  <= lk[2] * lk[3];
      p_lon_q <= lk[1] * lk[1];
      p_lat_q <= lk[0] * lk[0];
    end
    if (en[S5+1]) begin
      m_cc_q  <= q31_norm(p_cc_q);
      m_lon_q <= q31_norm(p_lon_q);
      m_lat_q <= q31_norm(p_lat_q);
    end
    if (en[S5+2]) begin
      p4_q     <= p4_d;
      m_lat2_q <= m_lat_q;
    end
    if (en[S5+3]) begin
      rad_q <= (sum > 32'sd0) ? {sum[30:0], 31'd0} : 62'd0;
    end
    if (en[STAGE_SCALE]) begin
      prod_q <= 55'(TWO_RADIUS_M) * 55'(root);
    end
    if (en[STAGE_SCALE+1]) begin
      dist_q <= prod_q[54:31];
    end
  end

  hvd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[STAGE_SQRT +: SQRT_STEPS]),
    .rad_i  (rad_q),
    .root_o (root)
  );

  assign distance_m_o = dist_q;

endmodule

@@ hw/rtl/hvd_checker.sv @@
// Port-level checks for the haversine distance pipeline, bound to the top level.
// Depends on the port list of haversine_distance_q31 only.
module hvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] distance_m_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result withdrawn before its transfer.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(distance_m_o))
    else $error("Stalled result changed.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_m_o < 24'd12745590)
    else $error("Distance exceeds twice the Earth radius.");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input refused while the pipeline can still move.");

endmodule

bind haversine_distance_q31 hvd_checker u_hvd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .distance_m_o (distance_m_o)
);
